>>> hdl/overlap_set_enter_exit_tracker_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the overlap set tracker
// Concurrent checks, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef OVERLAP_SET_ENTER_EXIT_TRACKER_TOP_MACROS_SVH
`define OVERLAP_SET_ENTER_EXIT_TRACKER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define OSET_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define OSET_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define OSET_ASSERT(lbl, clk, rstn, prop, msg)
`define OSET_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

>>> hdl/oset_pkg.sv
// ----------------------------------------------------------------------------
// oset_pkg
// Shared types and constants of the overlap set tracker.
// ----------------------------------------------------------------------------
package oset_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int ID_BITS_DEF  = 16;
  localparam int ID_W         = 16;
  localparam int KIND_W       = 2;

  localparam logic [KIND_W-1:0] EV_ADDED   = 2'd0;
  localparam logic [KIND_W-1:0] EV_REMOVED = 2'd1;
  localparam logic [KIND_W-1:0] EV_DONE    = 2'd2;
  localparam logic [KIND_W-1:0] EV_DROPPED = 2'd3;

  localparam logic CMD_OVERLAP = 1'b0;
  localparam logic CMD_EOF     = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  // previous-frame entry, handed from cell to cell during the drain
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            vld;
    logic            seen;
  } prv_ent_t;

  typedef struct packed {
    logic ins;    // store compare id in the current slot
    logic mark;   // set seen mark of the previous slot
    logic shift;  // take previous entry from the right neighbor
    logic swap;   // current slot moves into the previous slot
  } cell_cmd_t;

endpackage

>>> hdl/overlap_set_enter_exit_tracker_top.sv
// ----------------------------------------------------------------------------
// overlap_set_enter_exit_tracker_top
// Frame-to-frame enter/exit tracking of object ids over a row of set cells.
// ----------------------------------------------------------------------------
// An overlap word's id is compared against every stored id of both sets at
// once and, if new, written into the first free cell; an added or dropped
// event goes to the output register. An end-of-frame word starts a drain:
// after the accepting cycle the previous row shifts one cell per cycle toward
// cell 0, which reports unseen ids as removed, and a closing cycle reports
// frame done and moves the current row into the previous row. Input is not
// taken during that drain, and a stalled output register holds back every
// drain cycle and every incoming word.
module overlap_set_enter_exit_tracker_top #(
  parameter int CAPACITY = oset_pkg::CAPACITY_DEF,
  parameter int ID_BITS  = oset_pkg::ID_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_command,
  input  logic [oset_pkg::ID_W-1:0]   in_object_id,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [oset_pkg::KIND_W-1:0] out_event_kind,
  output logic [oset_pkg::ID_W-1:0]   out_object_id_res,
  output logic                        out_last
);
  import oset_pkg::*;

  `include "overlap_set_enter_exit_tracker_top_macros.svh"

  localparam logic [ID_W-1:0] IdMask =
    (ID_BITS >= ID_W) ? {ID_W{1'b1}} : ID_W'((64'd1 << ID_BITS) - 64'd1);

  state_t state_r, state_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0] out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic              out_last_r, out_last_nxt;

  logic [ID_W-1:0]     id_masked;
  cell_cmd_t           cmd [CAPACITY];
  prv_ent_t            prv_ent [CAPACITY];
  prv_ent_t            nbr_ent [CAPACITY];
  logic [CAPACITY-1:0] cur_vld_vec, cur_hit_vec, prv_hit_vec, prv_vld_vec, first_free;

  logic can_load, in_fire, ov_fire, eof_fire, full, ins, step, head_vld;
  logic shift, swap, load;

  assign id_masked = in_object_id & IdMask;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      if (gi == CAPACITY - 1) begin : g_end
        assign nbr_ent[gi] = '0;
      end else begin : g_mid
        assign nbr_ent[gi] = prv_ent[gi+1];
      end
      if (gi == 0) begin : g_first
        assign first_free[gi] = !cur_vld_vec[gi];
      end else begin : g_rest
        assign first_free[gi] = !cur_vld_vec[gi] && cur_vld_vec[gi-1];
      end
      assign prv_vld_vec[gi] = prv_ent[gi].vld;
      assign cmd[gi].ins     = ins && first_free[gi];
      assign cmd[gi].mark    = ins && prv_hit_vec[gi];
      assign cmd[gi].shift   = shift;
      assign cmd[gi].swap    = swap;

      oset_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd[gi]),
        .cmp_id  (id_masked),
        .nbr_ent (nbr_ent[gi]),
        .prv_ent (prv_ent[gi]),
        .cur_vld (cur_vld_vec[gi]),
        .cur_hit (cur_hit_vec[gi]),
        .prv_hit (prv_hit_vec[gi])
      );
    end
  endgenerate

  assign full     = cur_vld_vec[CAPACITY-1];
  assign head_vld = prv_ent[0].vld;
  assign can_load = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (eof_fire) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (step && !head_vld) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and cell commands
  always_comb begin
    in_ready     = 1'b0;
    step         = 1'b0;
    load         = 1'b0;
    out_kind_nxt = out_kind_r;
    out_id_nxt   = out_id_r;
    out_last_nxt = out_last_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = can_load;
        if (ov_fire && !(|cur_hit_vec) && (full || !(|prv_hit_vec))) begin
          load         = 1'b1;
          out_kind_nxt = full ? EV_DROPPED : EV_ADDED;
          out_id_nxt   = id_masked;
          out_last_nxt = 1'b1;
        end
      end
      ST_DRAIN: begin
        step = can_load;
        if (step) begin
          if (!head_vld) begin
            load         = 1'b1;
            out_kind_nxt = EV_DONE;
            out_id_nxt   = '0;
            out_last_nxt = 1'b1;
          end else if (!prv_ent[0].seen) begin
            load         = 1'b1;
            out_kind_nxt = EV_REMOVED;
            out_id_nxt   = prv_ent[0].id;
            out_last_nxt = 1'b0;
          end
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign in_fire  = in_valid && in_ready;
  assign ov_fire  = in_fire && (in_command == CMD_OVERLAP);
  assign eof_fire = in_fire && (in_command == CMD_EOF);
  assign ins      = ov_fire && !(|cur_hit_vec) && !full;
  assign shift    = step && head_vld;
  assign swap     = step && !head_vld;

  assign out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind_r <= out_kind_nxt;
      out_id_r   <= out_id_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_kind    = out_kind_r;
  assign out_object_id_res = out_id_r;
  assign out_last          = out_last_r;

  // both rows stay packed toward cell 0
  `OSET_ASSERT(a_cur_packed, clk, rst_n, ((cur_vld_vec & (cur_vld_vec + CAPACITY'(1))) == '0), "current row not packed")
  `OSET_ASSERT(a_prv_packed, clk, rst_n, ((prv_vld_vec & (prv_vld_vec + CAPACITY'(1))) == '0), "previous row not packed")
  `OSET_ASSERT_NEXT(a_eof_drain, clk, rst_n, eof_fire, state_r == ST_DRAIN, "end of frame did not start drain")
  `OSET_ASSERT_NEXT(a_swap_empty, clk, rst_n, swap, (cur_vld_vec == '0) && (state_r == ST_IDLE), "current row not cleared at frame done")

endmodule

>>> hdl/oset_cell.sv
// ----------------------------------------------------------------------------
// oset_cell
// One slot of the current set and one slot of the previous set.
// ----------------------------------------------------------------------------
module oset_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  oset_pkg::cell_cmd_t       cmd,
  input  logic [oset_pkg::ID_W-1:0] cmp_id,
  input  oset_pkg::prv_ent_t        nbr_ent,
  output oset_pkg::prv_ent_t        prv_ent,
  output logic                      cur_vld,
  output logic                      cur_hit,
  output logic                      prv_hit
);
  import oset_pkg::*;

  logic [ID_W-1:0] cur_id_r, cur_id_nxt;
  logic            cur_vld_r, cur_vld_nxt;
  logic [ID_W-1:0] prv_id_r, prv_id_nxt;
  logic            prv_vld_r, prv_vld_nxt;
  logic            prv_seen_r, prv_seen_nxt;

  always_comb begin
    cur_id_nxt   = cur_id_r;
    cur_vld_nxt  = cur_vld_r;
    prv_id_nxt   = prv_id_r;
    prv_vld_nxt  = prv_vld_r;
    prv_seen_nxt = prv_seen_r;
    if (cmd.swap) begin
      prv_id_nxt   = cur_id_r;
      prv_vld_nxt  = cur_vld_r;
      prv_seen_nxt = 1'b0;
      cur_vld_nxt  = 1'b0;
    end else if (cmd.shift) begin
      prv_id_nxt   = nbr_ent.id;
      prv_vld_nxt  = nbr_ent.vld;
      prv_seen_nxt = nbr_ent.seen;
    end else begin
      if (cmd.ins) begin
        cur_id_nxt  = cmp_id;
        cur_vld_nxt = 1'b1;
      end
      if (cmd.mark) begin
        prv_seen_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r  <= 1'b0;
      prv_vld_r  <= 1'b0;
      prv_seen_r <= 1'b0;
    end else begin
      cur_vld_r  <= cur_vld_nxt;
      prv_vld_r  <= prv_vld_nxt;
      prv_seen_r <= prv_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_id_r <= cur_id_nxt;
    prv_id_r <= prv_id_nxt;
  end

  assign cur_vld      = cur_vld_r;
  assign cur_hit      = cur_vld_r && (cur_id_r == cmp_id);
  assign prv_hit      = prv_vld_r && (prv_id_r == cmp_id);
  assign prv_ent.id   = prv_id_r;
  assign prv_ent.vld  = prv_vld_r;
  assign prv_ent.seen = prv_seen_r;

endmodule
